FILE: sv/rtpp_pkg.sv
// Shared types, constants and tables for the radar target polar presence unit.
`timescale 1ns / 1ps

package rtpp_pkg;

	// Largest CORDIC step count that the arctangent table supports.
	localparam int MAX_STEPS = 24;
	localparam int STEP_W    = 5;

	// Field widths.
	localparam int FLD_W = 16;
	localparam int AGE_W = 17;
	localparam logic [AGE_W-1:0] AGE_MAX = 17'h1FFFF;

	// CORDIC working widths: x and y carry 12 fraction bits plus gain growth,
	// z is in degrees times 2^16.
	localparam int XY_W   = 31;
	localparam int Z_W    = 26;
	localparam int ATAN_W = 22;
	localparam int B_W    = 36;
	localparam int PROD_W = 62;

	// Configuration register indexes.
	localparam logic REG_FAST_OFF_EN    = 1'b0;
	localparam logic REG_FAST_OFF_LIMIT = 1'b1;

	// Input kinds carried on the slave tuser bit.
	localparam logic FUNC_REPORT = 1'b0;
	localparam logic FUNC_TICK   = 1'b1;

	localparam logic [FLD_W-1:0] FAST_OFF_LIMIT_RST = 16'd1000;

	// atan(2^-i) in degrees times 2^16, rounded.
	localparam logic [ATAN_W-1:0] ATAN_TAB [MAX_STEPS] = '{
		22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
		22'd234379,  22'd117304,  22'd58666,  22'd29335,
		22'd14668,   22'd7334,    22'd3667,   22'd1833,
		22'd917,     22'd458,     22'd229,    22'd115,
		22'd57,      22'd29,      22'd14,     22'd7,
		22'd4,       22'd2,       22'd1,      22'd0
	};

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic              tick;    // count one millisecond
		logic              report;  // capture a report and decide presence
		logic              pre;     // quadrant pre-rotation
		logic              iter;    // one CORDIC micro-rotation
		logic [STEP_W-1:0] step;    // index of that micro-rotation
		logic              fin;     // bearing sum and range product
		logic              load;    // round, saturate and fill the output register
	} rtpp_cmd_t;

endpackage

FILE: sv/rtpp_ctrl.sv
// Controller state machine: input and output handshakes and CORDIC sequencing.
`timescale 1ns / 1ps

module rtpp_ctrl import rtpp_pkg::*; #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_valid,
	input  logic      s_func,
	output logic      s_ready,
	output logic      m_valid,
	input  logic      m_ready,
	output rtpp_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PRE  = 3'd1;
	localparam logic [2:0] ST_ITER = 3'd2;
	localparam logic [2:0] ST_FIN  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

	logic [2:0]        state_q, state_d;
	logic [STEP_W-1:0] step_q;
	logic              m_valid_q;
	logic              s_acc;
	logic              load;

	assign s_ready = (state_q == ST_IDLE);
	assign s_acc   = s_valid && s_ready;
	assign load    = (state_q == ST_OUT) && (!m_valid_q || m_ready);
	assign m_valid = m_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_acc && s_func == FUNC_REPORT) state_d = ST_PRE;
			end
			ST_PRE:  state_d = ST_ITER;
			ST_ITER: begin
				if (step_q == LAST_STEP) state_d = ST_FIN;
			end
			ST_FIN:  state_d = ST_OUT;
			ST_OUT: begin
				if (load) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			step_q    <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_ITER) step_q <= step_q + 1'b1;
			else                    step_q <= '0;
			if (load)         m_valid_q <= 1'b1;
			else if (m_ready) m_valid_q <= 1'b0;
		end
	end

	always_comb begin
		cmd        = '0;
		cmd.tick   = s_acc && (s_func == FUNC_TICK);
		cmd.report = s_acc && (s_func == FUNC_REPORT);
		cmd.pre    = (state_q == ST_PRE);
		cmd.iter   = (state_q == ST_ITER);
		cmd.step   = step_q;
		cmd.fin    = (state_q == ST_FIN);
		cmd.load   = load;
	end

endmodule

FILE: sv/rtpp_dp.sv
// Datapath: report and age state, presence decision, CORDIC and output register.
`timescale 1ns / 1ps

module rtpp_dp import rtpp_pkg::*; #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  rtpp_cmd_t               cmd,
	input  logic                    cfg_we,
	input  logic                    cfg_index,
	input  logic [FLD_W-1:0]        cfg_data,
	input  logic signed [FLD_W-1:0] in_x,
	input  logic signed [FLD_W-1:0] in_y,
	input  logic signed [FLD_W-1:0] in_speed,
	input  logic signed [FLD_W-1:0] in_res,
	output logic                    out_present,
	output logic signed [FLD_W-1:0] out_x,
	output logic signed [FLD_W-1:0] out_y,
	output logic signed [FLD_W-1:0] out_speed,
	output logic signed [FLD_W-1:0] out_res,
	output logic signed [FLD_W-1:0] out_bearing,
	output logic [FLD_W-1:0]        out_range
);

	// Inverse CORDIC gain in Q32.
	localparam longint GAIN_INV = 64'd2608131496 + (64'd1738754330 >> (2 * CORDIC_STEPS));
	localparam logic [31:0] K_Q32 = 32'(GAIN_INV);
	localparam logic signed [Z_W-1:0] Z_P90 = Z_W'(90 * 65536);
	localparam logic signed [Z_W-1:0] Z_M90 = -Z_W'(90 * 65536);
	localparam logic signed [B_W-1:0] B_BASE = B_W'(64'd9000 * 65536 + 32768);
	localparam logic [PROD_W:0] RND = (PROD_W + 1)'(64'd1 << 43);
	localparam logic signed [19:0] B_MIN = -20'sd9000;
	localparam logic signed [19:0] B_MAX = 20'sd27000;

	logic                    fo_en_q;
	logic [FLD_W-1:0]        fo_limit_q;
	logic signed [FLD_W-1:0] last_x_q, last_y_q, last_speed_q, last_res_q;
	logic [AGE_W-1:0]        age_q, age_rep;
	logic                    present_q, present_d;
	logic                    origin_q;

	logic signed [XY_W-1:0]  cx_q, cy_q, px, py, dx, dy;
	logic signed [Z_W-1:0]   cz_q, atan_z;
	logic signed [B_W-1:0]   z_ext, b_s1;
	logic [PROD_W-1:0]       prod_s1;
	logic [PROD_W:0]         prod_rnd;
	logic [18:0]             rng_full;
	logic signed [19:0]      b_sh;
	logic signed [FLD_W-1:0] bearing_d;
	logic [FLD_W-1:0]        range_d;
	logic                    changed;

	// Report: with fast-off enabled, a change restarts the age of a stored target.
	assign changed = (in_x != last_x_q) || (in_y != last_y_q) ||
	                 (in_speed != last_speed_q) || (in_res != last_res_q);
	assign age_rep = (fo_en_q && last_res_q != '0 && changed) ? '0 : age_q;
	assign present_d = (in_res != '0) &&
	                   (!fo_en_q || age_rep <= {1'b0, fo_limit_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fo_en_q      <= 1'b0;
			fo_limit_q   <= FAST_OFF_LIMIT_RST;
			last_x_q     <= '0;
			last_y_q     <= '0;
			last_speed_q <= '0;
			last_res_q   <= '0;
			age_q        <= '0;
			present_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_FAST_OFF_EN:    fo_en_q    <= cfg_data[0];
					REG_FAST_OFF_LIMIT: fo_limit_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.tick && age_q != AGE_MAX) age_q <= age_q + 1'b1;
			if (cmd.report) begin
				age_q        <= age_rep;
				last_x_q     <= in_x;
				last_y_q     <= in_y;
				last_speed_q <= in_speed;
				last_res_q   <= in_res;
				present_q    <= present_d;
			end
		end
	end

	// CORDIC vectoring, one micro-rotation per cycle.
	assign px     = {{(XY_W-FLD_W-12){last_x_q[FLD_W-1]}}, last_x_q, 12'd0};
	assign py     = {{(XY_W-FLD_W-12){last_y_q[FLD_W-1]}}, last_y_q, 12'd0};
	assign dx     = cy_q >>> cmd.step;
	assign dy     = cx_q >>> cmd.step;
	assign atan_z = Z_W'(ATAN_TAB[cmd.step]);

	always_ff @(posedge clk) begin
		if (cmd.pre) begin
			origin_q <= (last_x_q == '0) && (last_y_q == '0);
			if (!px[XY_W-1]) begin
				cx_q <= px;
				cy_q <= py;
				cz_q <= '0;
			end else if (!py[XY_W-1]) begin
				cx_q <= py;
				cy_q <= -px;
				cz_q <= Z_P90;
			end else begin
				cx_q <= -py;
				cy_q <= px;
				cz_q <= Z_M90;
			end
		end else if (cmd.iter) begin
			if (!cy_q[XY_W-1]) begin
				cx_q <= cx_q + dx;
				cy_q <= cy_q - dy;
				cz_q <= cz_q + atan_z;
			end else begin
				cx_q <= cx_q - dx;
				cy_q <= cy_q + dy;
				cz_q <= cz_q - atan_z;
			end
		end
	end

	// Finish, FIN state: bearing sum (times 100 by shifts) and range product.
	assign z_ext = B_W'(cz_q);

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			b_s1    <= B_BASE - ((z_ext <<< 6) + (z_ext <<< 5) + (z_ext <<< 2));
			prod_s1 <= cx_q[XY_W-1] ? '0 : PROD_W'(cx_q[XY_W-2:0]) * PROD_W'(K_Q32);
		end
	end

	// Finish, OUT state: floor shift, rounding and saturation.
	assign b_sh     = b_s1[B_W-1:16];
	assign prod_rnd = {1'b0, prod_s1} + RND;
	assign rng_full = prod_rnd[PROD_W:44];

	always_comb begin
		if (origin_q)          bearing_d = 16'sd9000;
		else if (b_sh < B_MIN) bearing_d = 16'(B_MIN);
		else if (b_sh > B_MAX) bearing_d = 16'(B_MAX);
		else                   bearing_d = b_sh[FLD_W-1:0];
		if (origin_q)                  range_d = '0;
		else if (rng_full[18:16] != '0) range_d = '1;
		else                           range_d = rng_full[FLD_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_present <= present_q;
			out_x       <= present_q ? last_x_q     : '0;
			out_y       <= present_q ? last_y_q     : '0;
			out_speed   <= present_q ? last_speed_q : '0;
			out_res     <= present_q ? last_res_q   : '0;
			out_bearing <= present_q ? bearing_d    : '0;
			out_range   <= present_q ? range_d      : '0;
		end
	end

endmodule

FILE: sv/radar_target_polar_presence_unit.sv
// m_axis_tvalid rises once an accepted report has passed pre-rotation, the micro-rotations,
// the finishing state and the output load. The single shared CORDIC stage does one
// micro-rotation per cycle, and the input stays closed until each report is loaded; a
// millisecond tick leaves the input open. The output register lets the next input beat in
// while a result still waits. Reset (arst_n low, asynchronous) clears stored report, age,
// valid flags and loads the register defaults: fast-off disabled, limit 1000 ms.
`timescale 1ns / 1ps

module radar_target_polar_presence_unit import rtpp_pkg::*; #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // pos_x, pos_y, speed_in, res_in (lowest first)
	input  logic        s_axis_tuser,  // func: 0 report, 1 millisecond tick
	// Result stream.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [95:0] m_axis_tdata,  // x_out, y_out, speed_out, res_out,
	                                   // bearing_cdeg, range_mm (lowest first)
	output logic        m_axis_tuser,  // present
	// Configuration write port.
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	rtpp_cmd_t cmd;

	logic signed [FLD_W-1:0] x_out, y_out, speed_out, res_out, bearing_cdeg;
	logic [FLD_W-1:0]        range_mm;

	// The controller owns both handshakes and steps the CORDIC; each
	// report passes through pre-rotation, the micro-rotations, and the
	// finishing and output states before it lands in the output register.
	rtpp_ctrl #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_axis_tvalid),
		.s_func  (s_axis_tuser),
		.s_ready (s_axis_tready),
		.m_valid (m_axis_tvalid),
		.m_ready (m_axis_tready),
		.cmd     (cmd)
	);

	// The datapath holds the stored report, the age counter, the
	// configuration and the output register.
	rtpp_dp #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_x        (s_axis_tdata[15:0]),
		.in_y        (s_axis_tdata[31:16]),
		.in_speed    (s_axis_tdata[47:32]),
		.in_res      (s_axis_tdata[63:48]),
		.out_present (m_axis_tuser),
		.out_x       (x_out),
		.out_y       (y_out),
		.out_speed   (speed_out),
		.out_res     (res_out),
		.out_bearing (bearing_cdeg),
		.out_range   (range_mm)
	);

	assign m_axis_tdata = {range_mm, bearing_cdeg, res_out, speed_out, y_out, x_out};

`ifndef NO_ASSERTIONS
	// An absent target delivers an all-zero beat.
	a_absent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
		else $error("absent target with nonzero payload");

	// The bearing of a present target stays within its saturation limits.
	a_bearing_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |->
			($signed(m_axis_tdata[79:64]) >= -16'sd9000) &&
			($signed(m_axis_tdata[79:64]) <= 16'sd27000))
		else $error("bearing out of range");

	// A report keeps the input closed while it is converted.
	a_report_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser == FUNC_REPORT |=> !s_axis_tready)
		else $error("input open during conversion");

	// A tick leaves the input ready in the cycle after it is accepted.
	a_tick_fast: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser == FUNC_TICK |=> s_axis_tready)
		else $error("tick did not return to idle");
`endif

endmodule
